// ----- hdl/ale_pkg.sv -----
// package with shared constants and types for the array list engine
`timescale 1ns / 1ps
package ale_pkg;
   localparam int DEPTH = 128;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [2:0] OP_CLEAR  = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1;
   localparam logic [2:0] OP_DELETE = 3'd2;
   localparam logic [2:0] OP_SEARCH = 3'd3;
   localparam logic [2:0] OP_MINMAX = 3'd4;
   localparam logic [2:0] OP_SORT   = 3'd5;
   localparam logic [2:0] OP_READ   = 3'd6;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_BADPOS   = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;

   typedef logic [2:0]  opcode_type;
   typedef logic [7:0]  position_type;
   typedef logic signed [31:0] word_type;
   typedef logic [2:0]  status_type;
endpackage

// ----- hdl/ale_ram.sv -----
// generic single port ram with registered read
`timescale 1ns / 1ps
module ale_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ----- hdl/array_list_engine_top.sv -----
// array list engine top level with sequencer around one element ram
`timescale 1ns / 1ps
// Usage: a request word (req_opcode, req_position, req_value) is taken when
// req_valid is high and req_stall is low. Exactly one response word comes out
// on the rsp_ ports per request, held while rsp_stall is high; a new request
// is not taken until the response has been delivered.
// Each element step walks the list with one ram access at a time through the
// single ram port: a read, then a write or compare.
// Reset clears the count and the control state; the ram holds no reset value
// and only entries below the count are ever read.
// While rsp_stall is high the response stays put and req_stall stays high.
module array_list_engine_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ale_pkg::opcode_type   req_opcode,
   input  ale_pkg::position_type req_position,
   input  ale_pkg::word_type     req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ale_pkg::status_type   rsp_status,
   output logic [6:0]            rsp_found_index,
   output ale_pkg::word_type     rsp_result_value,
   output ale_pkg::word_type     rsp_max_value,
   output logic [7:0]            rsp_element_count
);
   import ale_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_INS_RD = 4'd2,
      S_INS_WR = 4'd3, S_DEL_RD = 4'd4, S_DEL_WR = 4'd5, S_SCAN_RD = 4'd6,
      S_SCAN_CK = 4'd7, S_SI_RD = 4'd8, S_SJ_RD = 4'd9, S_SJ_CK = 4'd10,
      S_SW_I = 4'd11, S_READ_W = 4'd12, S_READ_D = 4'd13, S_RSP = 4'd14;

   logic [3:0]     state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   opcode_type     op_ff, op_in;
   logic [CW-1:0]  pos_ff, pos_in;
   word_type       val_ff, val_in;
   logic [CW-1:0]  i_ff, i_in, j_ff, j_in;
   word_type       a_ff, a_in, b_ff, b_in;
   status_type     st_ff, st_in;
   logic [6:0]     fi_ff, fi_in;
   word_type       res_ff, res_in, mx_ff, mx_in;

   logic           we;
   logic [AW-1:0]  addr;
   word_type       wdata, rdata;

   ale_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(we), .addr(addr), .wr_data(wdata), .rd_data(rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);
   assign rsp_status = st_ff;
   assign rsp_found_index = fi_ff;
   assign rsp_result_value = res_ff;
   assign rsp_max_value = mx_ff;
   assign rsp_element_count = 8'(count_ff);

   always_comb begin
      state_in = state_ff; count_in = count_ff; op_in = op_ff; pos_in = pos_ff;
      val_in = val_ff; i_in = i_ff; j_in = j_ff; a_in = a_ff; b_in = b_ff;
      st_in = st_ff; fi_in = fi_ff; res_in = res_ff; mx_in = mx_ff;
      we = 1'b0; addr = '0; wdata = val_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_opcode; pos_in = CW'(req_position); val_in = req_value;
               st_in = ST_OK; fi_in = '0; res_in = '0; mx_in = '0;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_RSP;
            priority case (op_ff)
               OP_CLEAR: count_in = '0;
               OP_INSERT: begin
                  if (count_ff >= CW'(DEPTH)) st_in = ST_FULL;
                  else if (pos_ff > count_ff) st_in = ST_BADPOS;
                  else begin
                     i_in = count_ff; state_in = S_INS_RD;
                  end
               end
               OP_DELETE, OP_READ: begin
                  if (count_ff == '0) st_in = ST_EMPTY;
                  else if (pos_ff >= count_ff) st_in = ST_BADPOS;
                  else if (op_ff == OP_READ) state_in = S_READ_W;
                  else begin
                     i_in = pos_ff; state_in = S_DEL_RD;
                  end
               end
               OP_SEARCH, OP_MINMAX: begin
                  if (count_ff == '0)
                     st_in = (op_ff == OP_SEARCH) ? ST_NOTFOUND : ST_EMPTY;
                  else begin
                     i_in = '0; state_in = S_SCAN_RD;
                     if (op_ff == OP_SEARCH) st_in = ST_NOTFOUND;
                  end
               end
               OP_SORT: begin
                  if (count_ff > CW'(1)) begin
                     i_in = '0; state_in = S_SI_RD;
                  end
               end
               default: ;
            endcase
         end
         S_INS_RD: begin
            if (i_ff == pos_ff) begin
               we = 1'b1; addr = AW'(pos_ff); wdata = val_ff;
               count_in = count_ff + CW'(1); state_in = S_RSP;
            end else begin
               addr = AW'(i_ff - CW'(1)); state_in = S_INS_WR;
            end
         end
         S_INS_WR: begin
            we = 1'b1; addr = AW'(i_ff); wdata = rdata;
            i_in = i_ff - CW'(1); state_in = S_INS_RD;
         end
         S_DEL_RD: begin
            if (i_ff + CW'(1) >= count_ff) begin
               count_in = count_ff - CW'(1); state_in = S_RSP;
            end else begin
               addr = AW'(i_ff + CW'(1)); state_in = S_DEL_WR;
            end
         end
         S_DEL_WR: begin
            we = 1'b1; addr = AW'(i_ff); wdata = rdata;
            i_in = i_ff + CW'(1); state_in = S_DEL_RD;
         end
         S_SCAN_RD: begin
            addr = AW'(i_ff); state_in = S_SCAN_CK;
         end
         S_SCAN_CK: begin
            state_in = S_SCAN_RD;
            if (op_ff == OP_SEARCH) begin
               if (rdata == val_ff) begin
                  st_in = ST_OK; fi_in = 7'(i_ff); state_in = S_RSP;
               end
            end else if (i_ff == '0) begin
               res_in = rdata; mx_in = rdata;
            end else begin
               if (rdata < res_ff) res_in = rdata;
               if (rdata > mx_ff) mx_in = rdata;
            end
            if (state_in != S_RSP) begin
               i_in = i_ff + CW'(1);
               if (i_ff + CW'(1) >= count_ff) state_in = S_RSP;
            end
         end
         S_SI_RD: begin
            addr = AW'(i_ff); j_in = i_ff + CW'(1); state_in = S_SJ_RD;
         end
         S_SJ_RD: begin
            if (j_ff == i_ff + CW'(1)) a_in = rdata;
            addr = AW'(j_ff); state_in = S_SJ_CK;
         end
         S_SJ_CK: begin
            if (a_ff > rdata) begin
               we = 1'b1; addr = AW'(j_ff); wdata = a_ff;
               b_in = rdata; state_in = S_SW_I;
            end else begin
               state_in = S_SW_I; b_in = a_ff;
            end
         end
         S_SW_I: begin
            a_in = b_ff;
            if (b_ff != a_ff) begin
               we = 1'b1; addr = AW'(i_ff); wdata = b_ff;
            end
            if (j_ff + CW'(1) < count_ff) begin
               j_in = j_ff + CW'(1); state_in = S_SJ_RD;
            end else if (i_ff + CW'(2) < count_ff) begin
               i_in = i_ff + CW'(1); state_in = S_SI_RD;
            end else state_in = S_RSP;
         end
         S_READ_W: begin
            addr = AW'(pos_ff); state_in = S_READ_D;
         end
         S_READ_D: begin
            res_in = rdata; state_in = S_RSP;
         end
         S_RSP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      op_ff <= op_in; pos_ff <= pos_in; val_ff <= val_in;
      i_ff <= i_in; j_ff <= j_in; a_ff <= a_in; b_ff <= b_in;
      st_ff <= st_in; fi_ff <= fi_in; res_ff <= res_in; mx_ff <= mx_in;
   end
endmodule

// ----- hdl/ale_checker.sv -----
// port level checker for the array list engine, bound to the top level
`timescale 1ns / 1ps
module ale_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_status,
   input logic [7:0] rsp_element_count
);
   import ale_pkg::*;

   a_no_req_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken while response pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped under stall");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_element_count <= 8'(DEPTH)) else $error("count out of range");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid) else $error("repeated response");
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("not busy after request");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall) else $error("not idle after reset");
endmodule

bind array_list_engine_top ale_checker u_ale_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
   .rsp_element_count(rsp_element_count)
);
